[rtl/core/mamc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mamc_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BYTES_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_EXECUTE = 2'd2,
    CMD_OTHER   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CLS_FIRST       = 3'd0,
    CLS_IN_SEQUENCE = 3'd1,
    CLS_BACKWARD    = 3'd2,
    CLS_OVERLAP     = 3'd3,
    CLS_GAP         = 3'd4,
    CLS_EXECUTE     = 3'd5,
    CLS_IGNORED     = 3'd6
  } class_t;

  // what one tracker reports for the beat it is looking at
  typedef struct packed {
    class_t             cls;
    logic [ADDR_W-1:0]  delta;
    logic [COUNT_W-1:0] ccount;
    logic [BYTES_W-1:0] bytes;
  } trk_res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

[rtl/core/mamc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mamc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] address;
  logic [15:0] byte_length;

  modport source (output valid, command, address, byte_length, input ready);
  modport sink   (input valid, command, address, byte_length, output ready);
endinterface

interface mamc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  access_class;
  logic [63:0] distance;
  logic [31:0] class_count;
  logic [31:0] kind_count;
  logic [47:0] tracker_bytes;

  modport source (output valid, access_class, distance, class_count, kind_count,
                  tracker_bytes, input ready);
  modport sink   (input valid, access_class, distance, class_count, kind_count,
                  tracker_bytes, output ready);
endinterface

`default_nettype wire

[rtl/core/memory_access_continuity_monitor.sv]
`timescale 1ns / 1ps
`default_nettype none

// port     dir  beat
// acc_in   in   command, address, byte_length
// res_out  out  access_class, distance, class_count, kind_count, tracker_bytes
//
// one beat per cycle sustained while res_out does not stall; a result reaches
// res_out through the input register, then the result register
// tracker classify and update run in the cycle between the two registers
// rst (synchronous) clears both trackers and the kind counters
// a stalled result register holds the input register, which holds acc_in

module memory_access_continuity_monitor (
  input wire logic clk,
  input wire logic rst,
  mamc_in_if.sink    acc_in,
  mamc_out_if.source res_out
);
  import mamc_pkg::*;

  logic               s1_valid;
  cmd_t               s1_command;
  logic [ADDR_W-1:0]  s1_address;
  logic [LEN_W-1:0]   s1_len;

  logic [COUNT_W-1:0] kind_totals [3];

  logic               out_valid;
  class_t             out_class;
  logic [ADDR_W-1:0]  out_dist;
  logic [COUNT_W-1:0] out_ccount;
  logic [COUNT_W-1:0] out_kcount;
  logic [BYTES_W-1:0] out_bytes;

  logic               advance;
  logic               in_ready;
  trk_res_t           rd_res;
  trk_res_t           wr_res;
  logic [COUNT_W-1:0] kind_next;

  class_t             class_next;
  logic [ADDR_W-1:0]  dist_next;
  logic [COUNT_W-1:0] ccount_next;
  logic [BYTES_W-1:0] bytes_next;

  assign advance  = s1_valid && (!out_valid || res_out.ready);
  assign in_ready = !s1_valid || advance;
  assign acc_in.ready = in_ready;

  mamc_tracker u_rd_trk (
    .clk         (clk),
    .rst         (rst),
    .upd         (advance && (s1_command == CMD_READ)),
    .address     (s1_address),
    .byte_length (s1_len),
    .res         (rd_res)
  );

  mamc_tracker u_wr_trk (
    .clk         (clk),
    .rst         (rst),
    .upd         (advance && (s1_command == CMD_WRITE)),
    .address     (s1_address),
    .byte_length (s1_len),
    .res         (wr_res)
  );

  always_comb begin
    kind_next   = '0;
    class_next  = CLS_IGNORED;
    dist_next   = '0;
    ccount_next = '0;
    bytes_next  = '0;
    case (s1_command)
      CMD_READ: begin
        kind_next   = sat_inc(kind_totals[0]);
        class_next  = rd_res.cls;
        dist_next   = rd_res.delta;
        ccount_next = rd_res.ccount;
        bytes_next  = rd_res.bytes;
      end
      CMD_WRITE: begin
        kind_next   = sat_inc(kind_totals[1]);
        class_next  = wr_res.cls;
        dist_next   = wr_res.delta;
        ccount_next = wr_res.ccount;
        bytes_next  = wr_res.bytes;
      end
      CMD_EXECUTE: begin
        kind_next  = sat_inc(kind_totals[2]);
        class_next = CLS_EXECUTE;
      end
      default: begin
        kind_next  = '0;
        class_next = CLS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= acc_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && acc_in.valid) begin
      s1_command <= cmd_t'(acc_in.command);
      s1_address <= acc_in.address;
      s1_len     <= acc_in.byte_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_totals[0] <= '0;
      kind_totals[1] <= '0;
      kind_totals[2] <= '0;
    end else if (advance) begin
      case (s1_command)
        CMD_READ:    kind_totals[0] <= kind_next;
        CMD_WRITE:   kind_totals[1] <= kind_next;
        CMD_EXECUTE: kind_totals[2] <= kind_next;
        default:     kind_totals[0] <= kind_totals[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_class  <= class_next;
      out_dist   <= dist_next;
      out_ccount <= ccount_next;
      out_kcount <= kind_next;
      out_bytes  <= bytes_next;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.access_class  = out_class;
  assign res_out.distance      = out_dist;
  assign res_out.class_count   = out_ccount;
  assign res_out.kind_count    = out_kcount;
  assign res_out.tracker_bytes = out_bytes;

  // an empty input register must never block the input side
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> acc_in.ready)
    else $error("input side stalled with empty input register");

  // ignored commands leave every numeric field zero
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_class == CLS_IGNORED)) |->
      (out_dist == '0 && out_kcount == '0 && out_ccount == '0 && out_bytes == '0))
    else $error("ignored beat carries nonzero fields");

  // first and in-sequence classes have no distance and no class counter
  a_first_seq_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_class == CLS_FIRST || out_class == CLS_IN_SEQUENCE)) |->
      (out_dist == '0 && out_ccount == '0))
    else $error("first or in-sequence beat carries distance or count");

  // execute beats are counted only, and the count has moved off zero
  a_execute_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_class == CLS_EXECUTE) |->
      (out_bytes == '0 && out_ccount == '0 && out_kcount != '0))
    else $error("execute beat fields inconsistent");

endmodule

`default_nettype wire

[rtl/core/mamc_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mamc_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        upd,
  input  wire logic [mamc_pkg::ADDR_W-1:0] address,
  input  wire logic [mamc_pkg::LEN_W-1:0]  byte_length,
  output mamc_pkg::trk_res_t               res
);
  import mamc_pkg::*;

  logic               started;
  logic [ADDR_W-1:0]  prev_addr;
  logic [ADDR_W-1:0]  exp_addr;
  logic [BYTES_W-1:0] byte_total;
  logic [COUNT_W-1:0] backward_total;
  logic [COUNT_W-1:0] overlap_total;
  logic [COUNT_W-1:0] gap_total;

  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] byte_total_next;
  logic [COUNT_W-1:0] backward_total_next;
  logic [COUNT_W-1:0] overlap_total_next;
  logic [COUNT_W-1:0] gap_total_next;
  logic [ADDR_W-1:0]  exp_addr_next;

  assign bytes_sum       = {1'b0, byte_total} + {{(BYTES_W+1-LEN_W){1'b0}}, byte_length};
  assign byte_total_next = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
  assign exp_addr_next   = address + {{(ADDR_W-LEN_W){1'b0}}, byte_length};

  always_comb begin
    backward_total_next = backward_total;
    overlap_total_next  = overlap_total;
    gap_total_next      = gap_total;
    res.cls    = CLS_IN_SEQUENCE;
    res.delta  = '0;
    res.ccount = '0;
    res.bytes  = byte_total_next;
    // backward wins over overlap, overlap over gap
    if (!started) begin
      res.cls = CLS_FIRST;
    end else if (address < prev_addr) begin
      backward_total_next = sat_inc(backward_total);
      res.cls    = CLS_BACKWARD;
      res.delta  = prev_addr - address;
      res.ccount = backward_total_next;
    end else if (address < exp_addr) begin
      overlap_total_next = sat_inc(overlap_total);
      res.cls    = CLS_OVERLAP;
      res.delta  = exp_addr - address;
      res.ccount = overlap_total_next;
    end else if (address > exp_addr) begin
      gap_total_next = sat_inc(gap_total);
      res.cls    = CLS_GAP;
      res.delta  = address - exp_addr;
      res.ccount = gap_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      prev_addr      <= '0;
      exp_addr       <= '0;
      byte_total     <= '0;
      backward_total <= '0;
      overlap_total  <= '0;
      gap_total      <= '0;
    end else if (upd) begin
      started        <= 1'b1;
      prev_addr      <= address;
      exp_addr       <= exp_addr_next;
      byte_total     <= byte_total_next;
      backward_total <= backward_total_next;
      overlap_total  <= overlap_total_next;
      gap_total      <= gap_total_next;
    end
  end

endmodule

`default_nettype wire

[test/access_continuity_checker.sv]
`timescale 1ns / 1ps

module access_continuity_checker (
  input  logic        clk,
  input  logic        rst,
  mamc_in_if          acc_in,
  mamc_out_if         res_out,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import mamc_pkg::*;

  typedef struct packed {
    class_t             cls;
    logic [ADDR_W-1:0]  delta;
    logic [COUNT_W-1:0] ccount;
    logic [COUNT_W-1:0] kcount;
    logic [BYTES_W-1:0] bytes;
  } access_result_t;

  // shadow of both trackers and the per-kind counters
  logic               started      [2];
  logic [ADDR_W-1:0]  prev_addr    [2];
  logic [ADDR_W-1:0]  next_addr    [2];
  logic [BYTES_W-1:0] byte_sum     [2];
  logic [COUNT_W-1:0] backward_cnt [2];
  logic [COUNT_W-1:0] overlap_cnt  [2];
  logic [COUNT_W-1:0] gap_cnt      [2];
  logic [COUNT_W-1:0] kind_cnt     [3];

  access_result_t pending_results[$];

  function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic access_result_t predict_access(input cmd_t cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [LEN_W-1:0] len);
    access_result_t r;
    int t;
    r = '0;
    r.cls = CLS_IGNORED;
    case (cmd)
      CMD_EXECUTE: begin
        kind_cnt[2] = bump_count(kind_cnt[2]);
        r.cls = CLS_EXECUTE;
        r.kcount = kind_cnt[2];
      end
      CMD_READ, CMD_WRITE: begin
        t = (cmd == CMD_WRITE) ? 1 : 0;
        kind_cnt[t] = bump_count(kind_cnt[t]);
        r.kcount = kind_cnt[t];
        if (BYTES_MAX - byte_sum[t] < {32'd0, len}) begin
          byte_sum[t] = BYTES_MAX;
        end else begin
          byte_sum[t] = byte_sum[t] + len;
        end
        r.bytes = byte_sum[t];
        if (!started[t]) begin
          started[t] = 1'b1;
          r.cls = CLS_FIRST;
        end else if (addr < prev_addr[t]) begin
          backward_cnt[t] = bump_count(backward_cnt[t]);
          r.cls = CLS_BACKWARD;
          r.delta = prev_addr[t] - addr;
          r.ccount = backward_cnt[t];
        end else if (addr < next_addr[t]) begin
          overlap_cnt[t] = bump_count(overlap_cnt[t]);
          r.cls = CLS_OVERLAP;
          r.delta = next_addr[t] - addr;
          r.ccount = overlap_cnt[t];
        end else if (addr > next_addr[t]) begin
          gap_cnt[t] = bump_count(gap_cnt[t]);
          r.cls = CLS_GAP;
          r.delta = addr - next_addr[t];
          r.ccount = gap_cnt[t];
        end else begin
          r.cls = CLS_IN_SEQUENCE;
        end
        prev_addr[t] = addr;
        // wraps modulo 2^64
        next_addr[t] = addr + len;
      end
      default: ;
    endcase
    return r;
  endfunction

  task report_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        started[i]      = 1'b0;
        prev_addr[i]    = '0;
        next_addr[i]    = '0;
        byte_sum[i]     = '0;
        backward_cnt[i] = '0;
        overlap_cnt[i]  = '0;
        gap_cnt[i]      = '0;
      end
      for (int i = 0; i < 3; i++) kind_cnt[i] = '0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual class %0d",
                   $time, res_out.access_class);
        end else begin
          want = pending_results.pop_front();
          report_field("access_class", want.cls, res_out.access_class);
          report_field("distance", want.delta, res_out.distance);
          report_field("class_count", want.ccount, res_out.class_count);
          report_field("kind_count", want.kcount, res_out.kind_count);
          report_field("tracker_bytes", want.bytes, res_out.tracker_bytes);
        end
      end
      if (acc_in.valid && acc_in.ready) begin
        pending_results = {pending_results,
                           predict_access(cmd_t'(acc_in.command), acc_in.address,
                                          acc_in.byte_length)};
      end
    end
    outstanding = pending_results.size();
  end

endmodule

[test/tb_memory_access_continuity_monitor.sv]
`timescale 1ns / 1ps

module tb_memory_access_continuity_monitor;
  import mamc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 370;
  localparam int unsigned LONG_HOLD       = 300;

  logic clk;
  logic rst;
  logic sink_hold;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatches;
  int unsigned outstanding;

  // address history per tracker as sent, used to steer the random mix
  logic [ADDR_W-1:0] sent_prev [2];
  logic [ADDR_W-1:0] sent_next [2];

  mamc_in_if  acc_ch ();
  mamc_out_if res_ch ();

  memory_access_continuity_monitor dut (
    .clk     (clk),
    .rst     (rst),
    .acc_in  (acc_ch),
    .res_out (res_ch)
  );

  access_continuity_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .acc_in      (acc_ch),
    .res_out     (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task send_access(input cmd_t cmd, input logic [ADDR_W-1:0] addr,
                   input logic [LEN_W-1:0] len);
    int t;
    while ($urandom_range(99) < send_idle_pct) begin
      acc_ch.valid <= 1'b0;
      @(negedge clk);
    end
    acc_ch.valid       <= 1'b1;
    acc_ch.command     <= cmd;
    acc_ch.address     <= addr;
    acc_ch.byte_length <= len;
    @(posedge clk);
    while (!acc_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      t = (cmd == CMD_WRITE) ? 1 : 0;
      sent_prev[t] = addr;
      sent_next[t] = addr + len;
    end
  endtask

  task send_random_access;
    int unsigned pick;
    int unsigned mode;
    int t;
    cmd_t cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_READ;
    else if (pick < 80) cmd = CMD_WRITE;
    else if (pick < 90) cmd = CMD_EXECUTE;
    else cmd = CMD_OTHER;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = '1;
      2:       len = 16'($urandom);
      default: len = 16'($urandom_range(1, 64));
    endcase
    t = (cmd == CMD_WRITE) ? 1 : 0;
    mode = $urandom_range(99);
    // mostly runs that follow on, with gaps, overlaps and jumps back mixed in
    if (cmd == CMD_EXECUTE || cmd == CMD_OTHER || mode >= 90) addr = {$urandom, $urandom};
    else if (mode < 55) addr = sent_next[t];
    else if (mode < 65) addr = sent_next[t] + $urandom_range(1, 256);
    else if (mode < 75) addr = sent_next[t] - $urandom_range(1, 8);
    else if (mode < 85) addr = sent_prev[t] - $urandom_range(1, 4096);
    else addr = {48'hFFFF_FFFF_FFFF, 16'($urandom)};
    send_access(cmd, addr, len);
  endtask

  task drain;
    acc_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned wait_cycles;
    rst                = 1'b1;
    sink_hold          = 1'b0;
    send_idle_pct      = 0;
    sink_stall_pct     = 0;
    acc_ch.valid       = 1'b0;
    acc_ch.command     = CMD_READ;
    acc_ch.address     = '0;
    acc_ch.byte_length = '0;
    res_ch.ready       = 1'b0;
    for (int i = 0; i < 2; i++) begin
      sent_prev[i] = '0;
      sent_next[i] = '0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // read tracker: first, in sequence, overlap, gap, backward, wrap of the next address
    send_access(CMD_READ, 64'd0, 16'd0);
    send_access(CMD_READ, 64'd0, 16'd0);
    send_access(CMD_READ, 64'd0, 16'd16);
    send_access(CMD_READ, 64'd8, 16'd8);
    send_access(CMD_READ, 64'd40, 16'd4);
    send_access(CMD_READ, 64'd4, 16'd0);
    send_access(CMD_READ, '1, '1);
    send_access(CMD_READ, 64'd0, 16'd1);
    send_access(CMD_READ, 64'd1, 16'd0);
    // write tracker starts at the top of the address space
    send_access(CMD_WRITE, '1, 16'd1);
    send_access(CMD_WRITE, 64'd0, '1);
    send_access(CMD_WRITE, 64'h0000_0000_0000_FFFF, 16'd0);
    send_access(CMD_WRITE, 64'h5555_5555_5555_5555, 16'hAAAA);
    send_access(CMD_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
    send_access(CMD_WRITE, 64'h5555_5555_5555_5555, 16'h5555);
    send_access(CMD_EXECUTE, 64'd0, 16'd0);
    send_access(CMD_EXECUTE, '1, '1);
    send_access(CMD_OTHER, '1, '1);
    send_access(CMD_OTHER, 64'd0, 16'd0);
    // other commands leave the trackers alone, so this one still follows on
    send_access(CMD_READ, 64'd1, 16'd3);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin send_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      if (phase == 0) begin
        // output held off while input keeps coming, so the pipe backs up
        fork
          begin
            @(posedge clk);
            sink_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_access();
      end
      drain();
    end

    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_memory_access_continuity_monitor passed");
    end else begin
      $display("tb_memory_access_continuity_monitor failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_memory_access_continuity_monitor failed");
    $finish;
  end

endmodule
